// File: hdl/csvfs_pkg.sv
package csvfs_pkg;

    localparam logic [7:0] QUOTE_CHAR  = 8'h22;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] NO_ESCAPE   = 8'h00;
    localparam logic [7:0] DELIM_RESET = 8'h2C;

    localparam logic REG_DELIM  = 1'b0;
    localparam logic REG_ESCAPE = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic quoted;
        logic esc_wait;
        logic quote_wait;
        logic nonempty;
    } flags_t;

    typedef struct packed {
        logic       run_last;
        logic       record_done;
        logic       field_done;
        logic       byte_valid;
        logic [7:0] data;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

endpackage

// File: hdl/csvfs_step.sv
module csvfs_step
(
    input  logic [7:0]           in_byte,
    input  logic                 line_last,
    input  logic [7:0]           delimiter_byte,
    input  logic [7:0]           escape_byte,
    input  csvfs_pkg::flags_t    flags,
    output csvfs_pkg::flags_t    flags_next,
    output csvfs_pkg::step_out_t res
);

    logic       app;
    logic       fend;
    logic [7:0] abyte;
    logic       outside;
    csvfs_pkg::flags_t nf;

    always_comb
    begin
        nf      = flags;
        app     = 1'b0;
        fend    = 1'b0;
        abyte   = in_byte;
        outside = 1'b0;

        if (flags.esc_wait)
        begin
            nf.esc_wait = 1'b0;
            app         = 1'b1;
            case (in_byte)
                csvfs_pkg::CHAR_N: abyte = csvfs_pkg::CHAR_LF;
                csvfs_pkg::CHAR_R: abyte = csvfs_pkg::CHAR_CR;
                csvfs_pkg::CHAR_T: abyte = csvfs_pkg::CHAR_TAB;
                default:           abyte = in_byte;
            endcase
        end
        else if (flags.quote_wait)
        begin
            nf.quote_wait = 1'b0;
            if (in_byte == csvfs_pkg::QUOTE_CHAR)
            begin
                app = 1'b1;
            end
            else
            begin
                nf.quoted = 1'b0;
                outside   = 1'b1;
            end
        end
        else if (flags.quoted)
        begin
            if (escape_byte != csvfs_pkg::NO_ESCAPE && in_byte == escape_byte)
            begin
                if (line_last)
                    app = 1'b1;
                else
                    nf.esc_wait = 1'b1;
            end
            else if (in_byte == csvfs_pkg::QUOTE_CHAR)
            begin
                if (!line_last && escape_byte == csvfs_pkg::NO_ESCAPE)
                    nf.quote_wait = 1'b1;
                else
                    nf.quoted = 1'b0;
            end
            else
            begin
                app = 1'b1;
            end
        end
        else
        begin
            outside = 1'b1;
        end

        if (outside)
        begin
            if (in_byte == csvfs_pkg::QUOTE_CHAR)
            begin
                if (!flags.nonempty)
                    nf.quoted = 1'b1;
                else
                    app = 1'b1;
            end
            else if (in_byte == delimiter_byte)
            begin
                nf.nonempty = 1'b0;
                fend        = 1'b1;
            end
            else
            begin
                app = 1'b1;
            end
        end

        if (app)
            nf.nonempty = 1'b1;

        res    = '0;
        res.r0 = '{run_last: 1'b0, record_done: 1'b0, field_done: fend,
                   byte_valid: app, data: app ? abyte : 8'h00};
        res.count = {1'b0, app | fend};

        if (line_last)
        begin
            if (app)
            begin
                res.r0.field_done  = 1'b1;
                res.r0.record_done = 1'b1;
            end
            else if (fend)
            begin
                res.r1.field_done  = 1'b1;
                res.r1.record_done = 1'b1;
                res.count          = 2'd2;
            end
            else
            begin
                res.r0.field_done  = 1'b1;
                res.r0.record_done = 1'b1;
                res.count          = 2'd1;
            end
            nf = '0;
        end

        if (res.count == 2'd2)
            res.r1.run_last = 1'b1;
        else
            res.r0.run_last = 1'b1;

        flags_next = nf;
    end

endmodule

// File: hdl/csvfs_fifo.sv
module csvfs_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  csvfs_pkg::result_t   push0,
    input  csvfs_pkg::result_t   push1,
    output logic                 room_two,
    output logic                 out_valid,
    input  logic                 out_ready,
    output csvfs_pkg::result_t   out_item
);

    csvfs_pkg::result_t                  mem_reg [csvfs_pkg::FIFO_DEPTH];
    logic [csvfs_pkg::PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [csvfs_pkg::PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [csvfs_pkg::CNT_W-1:0]         count_reg, count_next;
    logic                                pop;
    logic [csvfs_pkg::PTR_W-1:0]         wr_ptr_p1;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign room_two  = count_reg <= csvfs_pkg::CNT_W'(csvfs_pkg::FIFO_DEPTH - 2);
    assign wr_ptr_p1 = wr_ptr_reg + csvfs_pkg::PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + csvfs_pkg::PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + csvfs_pkg::PTR_W'(pop);
        count_next  = count_reg + csvfs_pkg::CNT_W'(push_count)
                      - csvfs_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            mem_reg[wr_ptr_p1] <= push1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= csvfs_pkg::CNT_W'(csvfs_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_count != 2'd0 |-> room_two)
        else $error("push without room");

endmodule

// File: hdl/csv_field_splitter.sv
// channel | dir | tdata         | tuser                                   | tlast
// s_axis  | in  | in_byte[7:0]  | -                                       | line_last
// m_axis  | out | out_byte[7:0] | byte_valid, field_done, record_done     | run_last
// cfg     | in  | cfg_index 0: delimiter_byte, 1: escape_byte; cfg_data[7:0]
// One byte per cycle while not stalled; input beats are registered before processing.
// A line-ending delimiter outside quotes yields two result beats; the four-entry result
// queue drains one beat per ready cycle, and input stalls while it holds more than two.
// Unless they end the line, bytes that open quoting or start a pending escape or quote
// yield no beat. rst_n clears quoting state and restores delimiter ',' and no escape.
module csv_field_splitter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [0] byte_valid, [1] field_done, [2] record_done
    output logic       m_axis_tlast
);

    logic [7:0]            delim_reg;
    logic [7:0]            escape_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    csvfs_pkg::flags_t     flags_reg, flags_next;
    csvfs_pkg::step_out_t  step_res;
    csvfs_pkg::result_t    head;
    logic                  room_two;
    logic                  process;
    logic [1:0]            push_count;

    assign process       = in_valid_reg && room_two;
    assign s_axis_tready = !in_valid_reg || process;
    assign push_count    = process ? step_res.count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg  <= csvfs_pkg::DELIM_RESET;
            escape_reg <= csvfs_pkg::NO_ESCAPE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csvfs_pkg::REG_DELIM:  delim_reg  <= cfg_data;
                csvfs_pkg::REG_ESCAPE: escape_reg <= cfg_data;
                default:               delim_reg  <= delim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            flags_reg    <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (process)
                flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    csvfs_step u_step
    (
        .in_byte        (in_byte_reg),
        .line_last      (in_last_reg),
        .delimiter_byte (delim_reg),
        .escape_byte    (escape_reg),
        .flags          (flags_reg),
        .flags_next     (flags_next),
        .res            (step_res)
    );

    csvfs_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (step_res.r0),
        .push1      (step_res.r1),
        .room_two   (room_two),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (head)
    );

    assign m_axis_tdata = head.data;
    assign m_axis_tuser = {head.record_done, head.field_done, head.byte_valid};
    assign m_axis_tlast = head.run_last;

    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        process && in_last_reg |=> flags_reg == '0)
        else $error("state not cleared at line end");

    a_line_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        process && in_last_reg |-> step_res.count != 2'd0)
        else $error("line end without record beat");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        process && step_res.count == 2'd2 |->
            step_res.r0.field_done && !step_res.r0.record_done
            && step_res.r1.record_done)
        else $error("bad two-beat order");

    a_record_has_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1] && m_axis_tlast)
        else $error("record end without field end");

endmodule

// File: tb/sv/csv_field_splitter_tb.sv
module csv_field_splitter_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 85;
    localparam int RAND_PHASES  = 8;
    localparam int LONG_HOLD    = 120;
    localparam int SETTLE       = 8;
    localparam int NPROBES      = 27;
    localparam int ESC_FROM     = 15;

    typedef struct packed {
        logic [7:0]         ch;
        logic               last;
        logic               fixed;
        csvfs_pkg::result_t want;
    } probe_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    // delimiter and escape copies, plus splitter state
    logic [7:0] delim_reg;
    logic [7:0] esc_reg;
    logic       in_quotes;
    logic       esc_pending;
    logic       quote_pending;
    logic       cell_open;

    csvfs_pkg::result_t step_res [$];
    csvfs_pkg::result_t beats_due [$];
    logic [7:0]         line_buf [$];

    int         fails;
    int         cycles;
    int         items;
    logic       calm;
    logic       stall_go;

    // rows 0..14 run with ',' and no escape; rows from ESC_FROM with ';' and '\'
    probe_t probes [NPROBES] = '{
        '{"a",                   1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 8'h61}},
        '{",",                   1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00}},
        '{8'hFF,                 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, 8'hFF}},
        '{8'h00,                 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 8'h00}},
        '{",",                   1'b1, 1'b0, '0},
        '{csvfs_pkg::QUOTE_CHAR, 1'b0, 1'b0, '0},
        '{",",                   1'b0, 1'b0, '0},
        '{csvfs_pkg::QUOTE_CHAR, 1'b0, 1'b0, '0},
        '{csvfs_pkg::QUOTE_CHAR, 1'b0, 1'b0, '0},
        '{csvfs_pkg::QUOTE_CHAR, 1'b0, 1'b0, '0},
        '{"x",                   1'b0, 1'b0, '0},
        '{csvfs_pkg::QUOTE_CHAR, 1'b0, 1'b0, '0},
        '{csvfs_pkg::QUOTE_CHAR, 1'b1, 1'b0, '0},
        '{csvfs_pkg::QUOTE_CHAR, 1'b0, 1'b0, '0},
        '{csvfs_pkg::QUOTE_CHAR, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00}},
        '{csvfs_pkg::QUOTE_CHAR, 1'b0, 1'b0, '0},
        '{"\\",                  1'b0, 1'b0, '0},
        '{csvfs_pkg::CHAR_N,     1'b0, 1'b0, '0},
        '{"\\",                  1'b0, 1'b0, '0},
        '{csvfs_pkg::CHAR_T,     1'b0, 1'b0, '0},
        '{"\\",                  1'b0, 1'b0, '0},
        '{csvfs_pkg::CHAR_R,     1'b0, 1'b0, '0},
        '{"\\",                  1'b0, 1'b0, '0},
        '{csvfs_pkg::QUOTE_CHAR, 1'b0, 1'b0, '0},
        '{";",                   1'b0, 1'b0, '0},
        '{"\\",                  1'b1, 1'b0, '0},
        '{";",                   1'b1, 1'b0, '0}
    };

    csv_field_splitter u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic void add_beat(input logic [7:0] d, input logic bv, input logic fd,
                                     input logic rd);
        csvfs_pkg::result_t r;
        r             = '0;
        r.data        = d;
        r.byte_valid  = bv;
        r.field_done  = fd;
        r.record_done = rd;
        step_res      = {step_res, r};
    endfunction

    function automatic void add_content(input logic [7:0] d);
        cell_open = 1'b1;
        add_beat(d, 1'b1, 1'b0, 1'b0);
    endfunction

    function automatic void unquoted_byte(input logic [7:0] c);
        if (c == csvfs_pkg::QUOTE_CHAR)
        begin
            if (!cell_open)
                in_quotes = 1'b1;
            else
                add_content(c);
        end
        else if (c == delim_reg)
        begin
            cell_open = 1'b0;
            add_beat(8'h00, 1'b0, 1'b1, 1'b0);
        end
        else
            add_content(c);
    endfunction

    function automatic void split_byte(input logic [7:0] c, input logic last);
        csvfs_pkg::result_t r;
        logic [7:0]         m;
        step_res.delete();
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            m = c;
            case (c)
                csvfs_pkg::CHAR_N: m = csvfs_pkg::CHAR_LF;
                csvfs_pkg::CHAR_R: m = csvfs_pkg::CHAR_CR;
                csvfs_pkg::CHAR_T: m = csvfs_pkg::CHAR_TAB;
                default:           m = c;
            endcase
            add_content(m);
        end
        else if (quote_pending)
        begin
            quote_pending = 1'b0;
            if (c == csvfs_pkg::QUOTE_CHAR)
                add_content(c);
            else
            begin
                in_quotes = 1'b0;
                unquoted_byte(c);
            end
        end
        else if (in_quotes)
        begin
            if (esc_reg != csvfs_pkg::NO_ESCAPE && c == esc_reg)
            begin
                if (last)
                    add_content(c);
                else
                    esc_pending = 1'b1;
            end
            else if (c == csvfs_pkg::QUOTE_CHAR)
            begin
                if (!last && esc_reg == csvfs_pkg::NO_ESCAPE)
                    quote_pending = 1'b1;
                else
                    in_quotes = 1'b0;
            end
            else
                add_content(c);
        end
        else
            unquoted_byte(c);

        if (last)
        begin
            if (step_res.size() > 0 && !step_res[step_res.size() - 1].field_done)
            begin
                r             = step_res[step_res.size() - 1];
                r.field_done  = 1'b1;
                r.record_done = 1'b1;
                step_res[step_res.size() - 1] = r;
            end
            else
                add_beat(8'h00, 1'b0, 1'b1, 1'b1);
            in_quotes     = 1'b0;
            esc_pending   = 1'b0;
            quote_pending = 1'b0;
            cell_open     = 1'b0;
        end

        if (step_res.size() > 0)
        begin
            r          = step_res[step_res.size() - 1];
            r.run_last = 1'b1;
            step_res[step_res.size() - 1] = r;
        end
    endfunction

    function automatic logic [7:0] pick_char();
        int k;
        k = $urandom_range(99);
        if (k < 15)
            return csvfs_pkg::QUOTE_CHAR;
        if (k < 30)
            return delim_reg;
        if (k < 38)
            return esc_reg;
        if (k < 48)
        begin
            case ($urandom_range(2))
                0:       return csvfs_pkg::CHAR_N;
                1:       return csvfs_pkg::CHAR_R;
                default: return csvfs_pkg::CHAR_T;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // hold the beat until accepted, then record what it should produce
    task automatic send_beat(input logic [7:0] b, input logic l, input logic fixed,
                             input csvfs_pkg::result_t want);
        int j;
        while (!calm && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items++;
        split_byte(b, l);
        if (fixed)
            beats_due = {beats_due, want};
        else
            for (j = 0; j < step_res.size(); j++)
                beats_due = {beats_due, step_res[j]};
    endtask

    task automatic drain(input int settle);
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] d, input logic [7:0] e);
        cfg_we    <= 1'b1;
        cfg_index <= csvfs_pkg::REG_DELIM;
        cfg_data  <= d;
        @(posedge clk);
        cfg_index <= csvfs_pkg::REG_ESCAPE;
        cfg_data  <= e;
        @(posedge clk);
        cfg_we    <= 1'b0;
        delim_reg = d;
        esc_reg   = e;
    endtask

    task automatic build_line();
        int         i;
        int         cells;
        int         len;
        logic [7:0] c;
        line_buf.delete();
        if ($urandom_range(99) < 25)
        begin
            len = $urandom_range(1, 10);
            repeat (len) line_buf = {line_buf, pick_char()};
            return;
        end
        cells = $urandom_range(1, 4);
        for (i = 0; i < cells; i++)
        begin
            if (i != 0)
                line_buf = {line_buf, delim_reg};
            len = $urandom_range(0, 6);
            if ($urandom_range(1) == 1)
            begin
                line_buf = {line_buf, csvfs_pkg::QUOTE_CHAR};
                repeat (len)
                begin
                    c = pick_char();
                    if (c == csvfs_pkg::QUOTE_CHAR
                        || (esc_reg != csvfs_pkg::NO_ESCAPE && c == esc_reg))
                        line_buf = {line_buf, ((esc_reg == csvfs_pkg::NO_ESCAPE)
                                               ? csvfs_pkg::QUOTE_CHAR : esc_reg)};
                    else if (esc_reg != csvfs_pkg::NO_ESCAPE
                             && (c == csvfs_pkg::CHAR_N || c == csvfs_pkg::CHAR_T)
                             && $urandom_range(1) == 1)
                        line_buf = {line_buf, esc_reg};
                    line_buf = {line_buf, c};
                end
                line_buf = {line_buf, csvfs_pkg::QUOTE_CHAR};
            end
            else
            begin
                repeat (len)
                begin
                    c = pick_char();
                    if (c == delim_reg
                        || (c == csvfs_pkg::QUOTE_CHAR && line_buf.size() == 0))
                        c = 8'h41 + 8'($urandom_range(25));
                    line_buf = {line_buf, c};
                end
            end
        end
        if (line_buf.size() == 0)
            line_buf = {line_buf, pick_char()};
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // sink: random back-pressure, long hold on request, check each beat
    initial
    begin
        int                 stall_left;
        csvfs_pkg::result_t want;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (beats_due.size() == 0)
                begin
                    $error("unexpected beat: tdata %h tuser %b tlast %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fails++;
                end
                else
                begin
                    want = beats_due.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        $error("out_byte: expected %h, got %h", want.data, m_axis_tdata);
                        fails++;
                    end
                    if (m_axis_tuser[0] !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %b, got %b",
                               want.byte_valid, m_axis_tuser[0]);
                        fails++;
                    end
                    if (m_axis_tuser[1] !== want.field_done)
                    begin
                        $error("field_done: expected %b, got %b",
                               want.field_done, m_axis_tuser[1]);
                        fails++;
                    end
                    if (m_axis_tuser[2] !== want.record_done)
                    begin
                        $error("record_done: expected %b, got %b",
                               want.record_done, m_axis_tuser[2]);
                        fails++;
                    end
                    if (m_axis_tlast !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last, m_axis_tlast);
                        fails++;
                    end
                end
            end
            if (stall_go)
            begin
                stall_go   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(99) >= 35);
        end
    end

    initial
    begin
        int         i;
        int         ph;
        int         start;
        logic [7:0] d;
        logic [7:0] e;
        fails         = 0;
        items         = 0;
        calm          = 1'b0;
        stall_go      = 1'b0;
        delim_reg     = csvfs_pkg::DELIM_RESET;
        esc_reg       = csvfs_pkg::NO_ESCAPE;
        in_quotes     = 1'b0;
        esc_pending   = 1'b0;
        quote_pending = 1'b0;
        cell_open     = 1'b0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= csvfs_pkg::REG_DELIM;
        cfg_data      <= 8'h00;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NPROBES; i++)
        begin
            if (i == ESC_FROM)
            begin
                s_axis_tvalid <= 1'b0;
                drain(SETTLE);
                set_regs(";", "\\");
            end
            send_beat(probes[i].ch, probes[i].last, probes[i].fixed, probes[i].want);
        end
        s_axis_tvalid <= 1'b0;

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain(SETTLE);
            case (ph)
                0:
                begin
                    d = 8'h00;
                    e = 8'hFF;
                end
                1:
                begin
                    d = 8'hFF;
                    e = csvfs_pkg::NO_ESCAPE;
                end
                2:
                begin
                    d = csvfs_pkg::QUOTE_CHAR;
                    e = "\\";
                end
                3:
                begin
                    d = csvfs_pkg::DELIM_RESET;
                    e = csvfs_pkg::QUOTE_CHAR;
                end
                default:
                begin
                    d = ($urandom_range(1) == 1) ? 8'($urandom_range(255))
                                                 : csvfs_pkg::CHAR_TAB;
                    e = ($urandom_range(2) == 0) ? csvfs_pkg::NO_ESCAPE
                                                 : 8'($urandom_range(255));
                end
            endcase
            set_regs(d, e);
            calm = (ph == 4);
            if (ph == 5)
                stall_go = 1'b1;
            start = items;
            while (items - start < PHASE_ITEMS)
            begin
                build_line();
                for (i = 0; i < line_buf.size(); i++)
                    send_beat(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
            end
            // leave a look-ahead pending across the next register change
            if ($urandom_range(1) == 1)
            begin
                send_beat(csvfs_pkg::QUOTE_CHAR, 1'b0, 1'b0, '0);
                send_beat(esc_reg != csvfs_pkg::NO_ESCAPE ? esc_reg : csvfs_pkg::QUOTE_CHAR,
                          1'b0, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
        end
        calm = 1'b0;

        drain(20);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
